// File: src/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types and codes of the bipartite maximum matching block.
// ----------------------------------------------------------------------------
package bmm_pkg;

  localparam int CMD_W = 2;
  localparam int VTX_W = 6;
  localparam int CNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd2;

  localparam logic REG_LEFT_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] LEFT_COUNT_RESET = 7'd64;
  localparam logic [CNT_W-1:0] COUNT_SAT = 7'd127;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PCLR,
    ST_PHASE,
    ST_ROOT,
    ST_ROOT_CHK,
    ST_FRAME,
    ST_ROW,
    ST_SCAN_FREE,
    ST_SCAN_PAIR,
    ST_POP,
    ST_POP_LD,
    ST_AUG_RD,
    ST_AUG_WR,
    ST_NEXT_ROOT,
    ST_DONE
  } state_t;

endpackage

// File: src/bmm_in_if.sv
// ----------------------------------------------------------------------------
// bmm_in_if
// Request channel of the matching block: command and edge endpoints.
// ----------------------------------------------------------------------------
interface bmm_in_if;
  logic                      valid;
  logic                      ready;
  logic [bmm_pkg::CMD_W-1:0] cmd;
  logic [bmm_pkg::VTX_W-1:0] left_vertex;
  logic [bmm_pkg::VTX_W-1:0] right_vertex;

  modport source (output valid, cmd, left_vertex, right_vertex, input ready);
  modport sink   (input valid, cmd, left_vertex, right_vertex, output ready);
endinterface

// File: src/bmm_out_if.sv
// ----------------------------------------------------------------------------
// bmm_out_if
// Result channel of the matching block: matching size and full-cover flag.
// ----------------------------------------------------------------------------
interface bmm_out_if;
  logic                      valid;
  logic                      ready;
  logic [bmm_pkg::CNT_W-1:0] matched_count;
  logic                      all_matched;

  modport source (output valid, matched_count, all_matched, input ready);
  modport sink   (input valid, matched_count, all_matched, output ready);
endinterface

// File: src/bipartite_max_matching.sv
// ----------------------------------------------------------------------------
// bipartite_max_matching
// Maximum bipartite matching by depth-first augmenting-path search.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch. A clear request empties the adjacency memory with a
// sweep over its MAX_LEFT rows; an edge request sets one bit and leaves the
// block idle, so edges load back to back. A solve request first clears the
// partner memories and then runs search phases until a phase adds no pair.
// Each search frame fetches its adjacency row and then scans the right partner
// memory, one right vertex per cycle; each augmenting step reads a stack entry
// and then rewrites the partner memories. The solve latency therefore depends
// on the graph.
// Only solve requests give a result, held in an output register on out_ch.
// While that result is stalled, further clear and edge requests are still
// taken; a second solve waits at its end until the register is free.
// After reset the adjacency memory is swept before the first request is taken.
// left_count is written over the cfg_ APB port.
// ----------------------------------------------------------------------------
module bipartite_max_matching #(
  parameter int MAX_LEFT  = 64,
  parameter int MAX_RIGHT = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  bmm_in_if.sink           in_ch,
  bmm_out_if.source        out_ch,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int LIDX  = $clog2(MAX_LEFT);
  localparam int RIDX  = $clog2(MAX_RIGHT);
  localparam int LP_W  = RIDX + 1;
  localparam int RP_W  = LIDX + 1;
  localparam int SP_W  = $clog2(MAX_LEFT + 1);
  localparam int POS_W = $clog2(MAX_RIGHT + 1);
  localparam int MT_W  = $clog2(MAX_LEFT + 1);
  localparam int CLR_N = (MAX_LEFT > MAX_RIGHT) ? MAX_LEFT : MAX_RIGHT;
  localparam int CLR_W = $clog2(CLR_N + 1);

  typedef struct packed {
    logic [LIDX-1:0]  node;
    logic [RIDX-1:0]  via;
    logic [POS_W-1:0] pos;
  } frame_t;

  bmm_pkg::state_t state_r, state_nxt;

  logic [CLR_W-1:0]         clr_r;
  logic [bmm_pkg::CNT_W-1:0] left_count_r;
  logic [MT_W-1:0]          n_r, root_r, match_total_r, root_inc;
  logic                     added_r;
  logic [MAX_LEFT-1:0]      visited_r;
  logic [SP_W-1:0]          sp_r, sp_m1, sp_m2;
  frame_t                   top_r;
  logic [POS_W-1:0]         sv_r;
  logic [RIDX-1:0]          dv_r;
  logic                     dvld_r;
  logic [SP_W-1:0]          walk_k_r, walk_km1;
  logic [RIDX-1:0]          walk_w_r;
  logic                     out_valid_r, out_all_r;
  logic [bmm_pkg::CNT_W-1:0] out_count_r;

  logic [MAX_RIGHT-1:0] adj_mem [MAX_LEFT];
  logic [MAX_RIGHT-1:0] adj_q;
  logic [LP_W-1:0]      lp_mem [MAX_LEFT];
  logic [LP_W-1:0]      lp_q;
  logic [RP_W-1:0]      rp_mem [MAX_RIGHT];
  logic [RP_W-1:0]      rp_q;
  frame_t               stk_mem [MAX_LEFT];
  frame_t               stk_q;

  logic in_acc, edge_ok, lp_free, rp_free, rp_pair, scan_ok, scan_end;
  logic sp_full, sp_last, out_free, cfg_wr;
  logic [MT_W-1:0] n_clamp;

  assign in_ch.ready = (state_r == bmm_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign edge_ok     = (32'(in_ch.left_vertex) < MAX_LEFT) &&
                       (32'(in_ch.right_vertex) < MAX_RIGHT);

  assign sp_m1    = sp_r - 1'b1;
  assign sp_m2    = sp_r - SP_W'(2);
  assign walk_km1 = walk_k_r - 1'b1;
  assign root_inc = root_r + 1'b1;
  assign sp_full  = 32'(sp_r) >= MAX_LEFT;
  assign sp_last  = (sp_r == SP_W'(1));
  assign lp_free  = (lp_q == '1);
  assign rp_free  = (rp_q == '1);
  assign rp_pair  = (32'(rp_q) < MAX_LEFT) && !visited_r[rp_q[LIDX-1:0]];
  assign scan_ok  = dvld_r && adj_q[dv_r] &&
                    ((state_r == bmm_pkg::ST_SCAN_FREE) ? rp_free : rp_pair);
  assign scan_end = !scan_ok && (sv_r == POS_W'(MAX_RIGHT));
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    if (left_count_r == '0) begin
      n_clamp = MT_W'(1);
    end else if (32'(left_count_r) > MAX_LEFT) begin
      n_clamp = MT_W'(MAX_LEFT);
    end else begin
      n_clamp = MT_W'(left_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmm_pkg::ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmm_pkg::ST_SWEEP: begin
        if (clr_r == CLR_W'(MAX_LEFT - 1)) state_nxt = bmm_pkg::ST_IDLE;
      end
      bmm_pkg::ST_IDLE: begin
        if (in_acc && in_ch.cmd == bmm_pkg::CMD_CLEAR) state_nxt = bmm_pkg::ST_SWEEP;
        if (in_acc && in_ch.cmd == bmm_pkg::CMD_SOLVE) state_nxt = bmm_pkg::ST_PCLR;
      end
      bmm_pkg::ST_PCLR: begin
        if (clr_r == CLR_W'(CLR_N - 1)) state_nxt = bmm_pkg::ST_PHASE;
      end
      bmm_pkg::ST_PHASE:    state_nxt = bmm_pkg::ST_ROOT;
      bmm_pkg::ST_ROOT:     state_nxt = bmm_pkg::ST_ROOT_CHK;
      bmm_pkg::ST_ROOT_CHK: state_nxt = lp_free ? bmm_pkg::ST_FRAME : bmm_pkg::ST_NEXT_ROOT;
      bmm_pkg::ST_FRAME:    state_nxt = bmm_pkg::ST_ROW;
      bmm_pkg::ST_ROW: begin
        if (top_r.pos == '0) begin
          state_nxt = bmm_pkg::ST_SCAN_FREE;
        end else begin
          state_nxt = sp_full ? bmm_pkg::ST_POP : bmm_pkg::ST_SCAN_PAIR;
        end
      end
      bmm_pkg::ST_SCAN_FREE: begin
        if (scan_ok) begin
          state_nxt = sp_last ? bmm_pkg::ST_NEXT_ROOT : bmm_pkg::ST_AUG_RD;
        end else if (scan_end) begin
          state_nxt = sp_full ? bmm_pkg::ST_POP : bmm_pkg::ST_SCAN_PAIR;
        end
      end
      bmm_pkg::ST_SCAN_PAIR: begin
        if (scan_ok) begin
          state_nxt = bmm_pkg::ST_FRAME;
        end else if (scan_end) begin
          state_nxt = bmm_pkg::ST_POP;
        end
      end
      bmm_pkg::ST_POP:    state_nxt = sp_last ? bmm_pkg::ST_NEXT_ROOT : bmm_pkg::ST_POP_LD;
      bmm_pkg::ST_POP_LD: state_nxt = bmm_pkg::ST_FRAME;
      bmm_pkg::ST_AUG_RD: state_nxt = bmm_pkg::ST_AUG_WR;
      bmm_pkg::ST_AUG_WR: begin
        state_nxt = (walk_k_r == SP_W'(1)) ? bmm_pkg::ST_NEXT_ROOT : bmm_pkg::ST_AUG_RD;
      end
      bmm_pkg::ST_NEXT_ROOT: begin
        if (root_inc == n_r) begin
          state_nxt = added_r ? bmm_pkg::ST_PHASE : bmm_pkg::ST_DONE;
        end else begin
          state_nxt = bmm_pkg::ST_ROOT;
        end
      end
      bmm_pkg::ST_DONE: begin
        if (out_free) state_nxt = bmm_pkg::ST_IDLE;
      end
      default: state_nxt = bmm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (state_r == bmm_pkg::ST_SWEEP || state_r == bmm_pkg::ST_PCLR) begin
      clr_r <= clr_r + 1'b1;
    end else begin
      clr_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      bmm_pkg::ST_IDLE: begin
        if (in_acc && in_ch.cmd == bmm_pkg::CMD_SOLVE) begin
          n_r           <= n_clamp;
          match_total_r <= '0;
        end
      end
      bmm_pkg::ST_PHASE: begin
        visited_r <= '0;
        added_r   <= 1'b0;
        root_r    <= '0;
      end
      bmm_pkg::ST_ROOT_CHK: begin
        if (lp_free) begin
          top_r.node <= root_r[LIDX-1:0];
          top_r.via  <= '0;
          top_r.pos  <= '0;
          sp_r       <= SP_W'(1);
          visited_r[root_r[LIDX-1:0]] <= 1'b1;
        end
      end
      bmm_pkg::ST_ROW: begin
        sv_r   <= top_r.pos;
        dvld_r <= 1'b0;
      end
      bmm_pkg::ST_SCAN_FREE, bmm_pkg::ST_SCAN_PAIR: begin
        if (scan_ok) begin
          if (state_r == bmm_pkg::ST_SCAN_FREE) begin
            walk_w_r      <= top_r.via;
            walk_k_r      <= sp_m1;
            match_total_r <= match_total_r + 1'b1;
            added_r       <= 1'b1;
          end else begin
            top_r.node <= rp_q[LIDX-1:0];
            top_r.via  <= dv_r;
            top_r.pos  <= '0;
            sp_r       <= sp_r + 1'b1;
            visited_r[rp_q[LIDX-1:0]] <= 1'b1;
          end
        end else if (scan_end) begin
          sv_r   <= top_r.pos;
          dvld_r <= 1'b0;
        end else begin
          dv_r   <= sv_r[RIDX-1:0];
          dvld_r <= 1'b1;
          sv_r   <= sv_r + 1'b1;
        end
      end
      bmm_pkg::ST_POP:       sp_r <= sp_m1;
      bmm_pkg::ST_POP_LD:    top_r <= stk_q;
      bmm_pkg::ST_AUG_WR: begin
        walk_w_r <= stk_q.via;
        walk_k_r <= walk_km1;
      end
      bmm_pkg::ST_NEXT_ROOT: root_r <= root_inc;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == bmm_pkg::ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bmm_pkg::ST_DONE && out_free) begin
      out_count_r <= (32'(match_total_r) > 32'(bmm_pkg::COUNT_SAT)) ?
                     bmm_pkg::COUNT_SAT : bmm_pkg::CNT_W'(match_total_r);
      out_all_r   <= (match_total_r >= n_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.matched_count = out_count_r;
  assign out_ch.all_matched   = out_all_r;

  always_ff @(posedge clk) begin
    if (state_r == bmm_pkg::ST_SWEEP) begin
      adj_mem[clr_r[LIDX-1:0]] <= '0;
    end else if (in_acc && in_ch.cmd == bmm_pkg::CMD_EDGE && edge_ok) begin
      adj_mem[LIDX'(in_ch.left_vertex)][RIDX'(in_ch.right_vertex)] <= 1'b1;
    end
    if (state_r == bmm_pkg::ST_FRAME) begin
      adj_q <= adj_mem[top_r.node];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bmm_pkg::ST_PCLR && 32'(clr_r) < MAX_LEFT) begin
      lp_mem[clr_r[LIDX-1:0]] <= '1;
    end else if (state_r == bmm_pkg::ST_SCAN_FREE && scan_ok) begin
      lp_mem[top_r.node] <= {1'b0, dv_r};
    end else if (state_r == bmm_pkg::ST_AUG_WR) begin
      lp_mem[stk_q.node] <= {1'b0, walk_w_r};
    end
    if (state_r == bmm_pkg::ST_ROOT) begin
      lp_q <= lp_mem[root_r[LIDX-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bmm_pkg::ST_PCLR && 32'(clr_r) < MAX_RIGHT) begin
      rp_mem[clr_r[RIDX-1:0]] <= '1;
    end else if (state_r == bmm_pkg::ST_SCAN_FREE && scan_ok) begin
      rp_mem[dv_r] <= {1'b0, top_r.node};
    end else if (state_r == bmm_pkg::ST_AUG_WR) begin
      rp_mem[walk_w_r] <= {1'b0, stk_q.node};
    end
    if ((state_r == bmm_pkg::ST_SCAN_FREE || state_r == bmm_pkg::ST_SCAN_PAIR) &&
        32'(sv_r) < MAX_RIGHT) begin
      rp_q <= rp_mem[sv_r[RIDX-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bmm_pkg::ST_SCAN_PAIR && scan_ok) begin
      stk_mem[sp_m1[LIDX-1:0]] <= '{node: top_r.node, via: top_r.via,
                                    pos: POS_W'(dv_r) + 1'b1};
    end
    if (state_r == bmm_pkg::ST_POP) begin
      stk_q <= stk_mem[sp_m2[LIDX-1:0]];
    end else if (state_r == bmm_pkg::ST_AUG_RD) begin
      stk_q <= stk_mem[walk_km1[LIDX-1:0]];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_count_r <= bmm_pkg::LEFT_COUNT_RESET;
    end else if (cfg_wr && cfg_paddr[2] == bmm_pkg::REG_LEFT_COUNT) begin
      left_count_r <= cfg_pwdata[bmm_pkg::CNT_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == bmm_pkg::REG_LEFT_COUNT) ?
                      {{(32 - bmm_pkg::CNT_W){1'b0}}, left_count_r} : 32'd0;

endmodule
